// File: hw/rtl/binary_thinning_subpass_core_assert.svh
// Assertion macros for the thinning sub-pass core.
// Each macro gives a labeled concurrent assertion clocked on the rising edge
// and disabled while the active-low reset is asserted.
`ifndef BINARY_THINNING_SUBPASS_CORE_ASSERT_SVH
`define BINARY_THINNING_SUBPASS_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define BTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define BTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BTS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/bts_pkg.sv
package bts_pkg;

	// Frame geometry limits.
	localparam int MaxWidth  = 4096;
	localparam int MaxHeight = 4096;
	localparam int MinDim    = 4;

	// Widths of the geometry registers and position counters.
	localparam int ColW    = $clog2(MaxWidth);
	localparam int DimW    = 13;
	localparam int RowW    = 13;
	localparam int CfgIdxW = 2;

	// Neighbor count limits for a removable pixel.
	localparam int MinSet = 2;
	localparam int MaxSet = 6;

	// Configuration register indexes.
	typedef enum logic [CfgIdxW-1:0] {
		CFG_IMAGE_WIDTH  = 2'd0,
		CFG_IMAGE_HEIGHT = 2'd1,
		CFG_PASS_SELECT  = 2'd2
	} cfg_index_t;

	// Per-word position flags passed from the position tracker down the pipe.
	typedef struct packed {
		logic primed;
		logic border;
		logic last;
	} pos_flags_t;

endpackage

// File: hw/rtl/bts_stream_if.sv
// Input stream: one binary pixel or flush marker per word.
interface bts_in_if;
	logic valid;
	logic ready;
	logic pixel_in;
	logic flush;

	modport source (output valid, output pixel_in, output flush, input ready);
	modport sink (input valid, input pixel_in, input flush, output ready);
endinterface

// Output stream: one thinned pixel per word, with end-of-frame status.
interface bts_out_if;
	logic valid;
	logic ready;
	logic pixel_out;
	logic frame_last;
	logic any_removed;

	modport source (output valid, output pixel_out, output frame_last, output any_removed,
		input ready);
	modport sink (input valid, input pixel_out, input frame_last, input any_removed,
		output ready);
endinterface

// File: hw/rtl/bts_position.sv
module bts_position (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic [bts_pkg::DimW-1:0] width,
	input  logic [bts_pkg::DimW-1:0] height,
	output logic [bts_pkg::ColW-1:0] col,
	output bts_pkg::pos_flags_t      flags
);
	import bts_pkg::*;

	logic [ColW-1:0] col_q;
	logic [RowW-1:0] row_q;
	logic            wrap_in;
	logic [RowW-1:0] row;
	logic [DimW-1:0] col_next;
	logic            wrap_out;

	// Position of the incoming word; a column left beyond a narrowed width wraps first.
	always_comb begin
		wrap_in  = {1'b0, col_q} >= width;
		col      = wrap_in ? '0 : col_q;
		row      = wrap_in ? row_q + 1'b1 : row_q;
		col_next = {1'b0, col} + 1'b1;
		wrap_out = col_next >= width;

		// The window center trails the input by one row and one column.
		flags.primed = (row >= RowW'(2)) || ((row == RowW'(1)) && (col != '0));
		flags.border = (col <= ColW'(1)) || (row == RowW'(1)) || (row >= height);
		flags.last   = (col == '0) && (row > height);
	end

	// Advance the raster counters on each accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (flags.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap_out) begin
				col_q <= '0;
				row_q <= row + 1'b1;
			end else begin
				col_q <= col_next[ColW-1:0];
				row_q <= row;
			end
		end
	end

endmodule

// File: hw/rtl/bts_line_buffer.sv
module bts_line_buffer (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [bts_pkg::ColW-1:0] rd_addr,
	input  logic                     px,
	input  logic                     wr_en,
	input  logic [bts_pkg::ColW-1:0] wr_addr,
	output logic                     top_s1,
	output logic                     mid_s1
);
	import bts_pkg::*;

	// Rows two and one above the input row.
	logic older_mem [MaxWidth];
	logic newer_mem [MaxWidth];

	// Read both rows at the input column; the new pixel replaces the newer row entry.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			top_s1             <= older_mem[rd_addr];
			mid_s1             <= newer_mem[rd_addr];
			newer_mem[rd_addr] <= px;
		end
	end

	// The displaced newer-row pixel moves to the older row as the word leaves the stage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			older_mem[wr_addr] <= mid_s1;
		end
	end

endmodule

// File: hw/rtl/bts_window.sv
module bts_window (
	input  logic clk,
	input  logic arst_n,
	input  logic shift_en,
	input  logic top,
	input  logic mid,
	input  logic px,
	input  logic pass_sel,
	input  logic border,
	output logic result,
	output logic cleared
);
	import bts_pkg::*;

	logic [8:0] window_q;
	logic [8:0] win_next;
	logic       removable;

	// Decide whether the center of a 3x3 window is removed in the given sub-pass.
	// Column-major layout: bits 0..2 west column, 3..5 center column, 6..8 east,
	// each column ordered north, center, south.
	function automatic logic clears_centre(input logic [8:0] w, input logic ps);
		logic [7:0] ring;
		logic [7:0] rise;
		logic [3:0] count;
		logic       p1;
		logic       p2;
		// Ring order N, NE, E, SE, S, SW, W, NW from bit 0 upward.
		ring  = {w[0], w[1], w[2], w[5], w[8], w[7], w[6], w[3]};
		rise  = ~ring & {ring[0], ring[7:1]};
		count = 4'($countones(ring));
		if (ps == 1'b0) begin
			p1 = w[3] & w[7] & w[5];
			p2 = w[7] & w[5] & w[1];
		end else begin
			p1 = w[3] & w[7] & w[1];
			p2 = w[3] & w[5] & w[1];
		end
		return w[4] && $onehot(rise) && (count >= 4'(MinSet)) && (count <= 4'(MaxSet))
			&& !p1 && !p2;
	endfunction

	// Next window: the new column enters on the east side.
	always_comb begin
		win_next  = {px, mid, top, window_q[8:3]};
		removable = clears_centre(win_next, pass_sel);
		cleared   = !border && removable;
		result    = win_next[4] && !cleared;
	end

	// Window shift register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (shift_en) begin
			window_q <= win_next;
		end
	end

endmodule

// File: hw/rtl/binary_thinning_subpass_core.sv
// One sub-pass of binary thinning over a raster-order pixel stream. The core
// accepts one word per clock unless the output is blocked, and returns the
// thinned pixel one row and one column behind the input. That result passes
// through the first-stage and output registers after the word completing its
// 3x3 window is accepted. One word per clock holds because each line store
// takes at most one read and one write per cycle. The first width+1 words of
// a frame produce no result, so the source appends width+1 flush words after
// each frame. The last result carries frame_last and, with it, any_removed.
// Pixels on the frame border pass unchanged. Width and height are saturated
// to 4..4096 when written and take effect at once, so registers should only be
// written while no word is in flight. The two 4096x1 line stores need no
// clearing after reset; a word may be accepted in the first cycle out of reset.
`include "binary_thinning_subpass_core_assert.svh"

module binary_thinning_subpass_core (
	input  logic                        clk,
	input  logic                        arst_n,
	bts_in_if.sink                      pix_in,
	bts_out_if.source                   pix_out,
	input  logic                        cfg_we,
	input  logic [bts_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [bts_pkg::DimW-1:0]    cfg_data
);
	import bts_pkg::*;

	logic [DimW-1:0] width_q;
	logic [DimW-1:0] height_q;
	logic            pass_q;

	logic            accept;
	logic            px;
	logic [ColW-1:0] col_s0;
	pos_flags_t      flags_s0;

	logic            valid_s1;
	logic            px_s1;
	logic [ColW-1:0] col_s1;
	pos_flags_t      flags_s1;
	logic            top_s1;
	logic            mid_s1;
	logic            advance_s1;

	logic            result;
	logic            cleared;
	logic            removed_q;

	logic            out_valid_q;
	logic            pixel_q;
	logic            last_q;
	logic            any_q;

	// Saturate a frame dimension to its legal range.
	function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
			input logic [DimW-1:0] hi);
		if (v < DimW'(MinDim)) begin
			return DimW'(MinDim);
		end else if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DimW'(640);
			height_q <= DimW'(480);
			pass_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= clamp_dim(cfg_data, DimW'(MaxWidth));
				CFG_IMAGE_HEIGHT: height_q <= clamp_dim(cfg_data, DimW'(MaxHeight));
				CFG_PASS_SELECT:  pass_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Handshake: the first stage moves on unless it holds a result and the output is blocked.
	assign advance_s1   = valid_s1 && (!flags_s1.primed || !out_valid_q || pix_out.ready);
	assign pix_in.ready = !valid_s1 || advance_s1;
	assign accept       = pix_in.valid && pix_in.ready;
	assign px           = pix_in.pixel_in && !pix_in.flush;

	bts_position u_position (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.width  (width_q),
		.height (height_q),
		.col    (col_s0),
		.flags  (flags_s0)
	);

	bts_line_buffer u_line_buffer (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_s0),
		.px      (px),
		.wr_en   (advance_s1),
		.wr_addr (col_s1),
		.top_s1  (top_s1),
		.mid_s1  (mid_s1)
	);

	// First pipeline stage: the accepted word and its position flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1    <= px;
			col_s1   <= col_s0;
			flags_s1 <= flags_s0;
		end
	end

	bts_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (advance_s1),
		.top      (top_s1),
		.mid      (mid_s1),
		.px       (px_s1),
		.pass_sel (pass_q),
		.border   (flags_s1.border),
		.result   (result),
		.cleared  (cleared)
	);

	// Frame-wide removal flag, cleared once the last result is produced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			removed_q <= 1'b0;
		end else if (advance_s1 && flags_s1.primed) begin
			if (flags_s1.last) begin
				removed_q <= 1'b0;
			end else if (cleared) begin
				removed_q <= 1'b1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && flags_s1.primed) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && flags_s1.primed) begin
			pixel_q <= result;
			last_q  <= flags_s1.last;
			any_q   <= flags_s1.last && (removed_q || cleared);
		end
	end

	assign pix_out.valid       = out_valid_q;
	assign pix_out.pixel_out   = pixel_q;
	assign pix_out.frame_last  = last_q;
	assign pix_out.any_removed = any_q;

	// The removal status appears only on the last word of a frame.
	`BTS_ASSERT_SAME(a_removed_only_on_last, clk, arst_n, pix_out.valid && !pix_out.frame_last, !pix_out.any_removed)
	// Input stalls only when a result is blocked behind a full output register.
	`BTS_ASSERT_SAME(a_stall_has_cause, clk, arst_n, !pix_in.ready, valid_s1 && flags_s1.primed && out_valid_q && !pix_out.ready)
	// The frame-wide flag starts clear after the last word of a frame.
	`BTS_ASSERT_NEXT(a_flag_cleared_at_end, clk, arst_n, advance_s1 && flags_s1.primed && flags_s1.last, removed_q == 1'b0)

endmodule
